// ===== rtl/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants of the sync frame Fletcher parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] NAV_CLASS   = 8'h01;
    localparam logic [7:0] NAV_PVT_ID  = 8'h07;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;
    localparam logic [15:0] NAV_MIN_RESET     = 16'd92;

    // Result kinds, carried on tuser.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CK_ERR  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_NAV_MIN     = 1'b1;

    localparam int TDATA_OUT_W = 128;

    typedef struct packed {
        logic [15:0] max_payload_length;
        logic [15:0] nav_min_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_class;
        logic [7:0]  msg_id;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
        logic        is_nav_solution;
        logic [31:0] good_frames;
        logic [31:0] checksum_errors;
    } result_t;

endpackage

// ===== rtl/sync_frame_fletcher_parser_top.sv =====
// ----------------------------------------------------------------------------
// sync_frame_fletcher_parser_top
// Sync frame parser with 8-bit Fletcher check: streams payload beats and
// reports each frame within the length limit as good or as a checksum error.
// ----------------------------------------------------------------------------
// Path: a payload or report beat is held in the input register, then in the
// result register, and waits there while the output is stalled.
// Throughput: one input beat per cycle unless a beat's result waits on a stalled
// output; the frame state machine updates once per beat between the registers.
// Reset: rst_n clears the parser, the counters and both stages at once and
// loads the register defaults (maximum payload 512, navigation minimum 92).
module sync_frame_fletcher_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    // Slave side.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    // Master side.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] frame_class, [15:8] msg_id, [31:16] byte_index, [39:32] data_byte,
    // [55:40] frame_length, [56] is_nav_solution, [88:57] good_frames,
    // [120:89] checksum_errors, [127:121] zero
    output logic [sfp_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic [1:0]   m_tuser    // [1:0] kind
);

    sfp_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             step;
    logic             res_valid;
    logic             slot_free;
    sfp_pkg::result_t res;
    sfp_pkg::result_t res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_length <= sfp_pkg::MAX_PAYLOAD_RESET;
            cfg_reg.nav_min_length     <= sfp_pkg::NAV_MIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfp_pkg::CFG_MAX_PAYLOAD: cfg_reg.max_payload_length <= cfg_data;
                sfp_pkg::CFG_NAV_MIN:     cfg_reg.nav_min_length     <= cfg_data;
                default:                  cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // A byte that gives no result moves on even while the output is stalled.
    assign slot_free = !m_tvalid || m_tready;
    assign step      = in_valid_reg && (slot_free || !res_valid);
    assign s_tready  = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    sfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && res_valid),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    assign m_tuser = res_out.kind;
    assign m_tdata = {7'd0,
                      res_out.checksum_errors,
                      res_out.good_frames,
                      res_out.is_nav_solution,
                      res_out.frame_length,
                      res_out.data_byte,
                      res_out.byte_index,
                      res_out.msg_id,
                      res_out.frame_class};

endmodule

// ===== rtl/sfp_parser.sv =====
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state machine: sync search, header capture, Fletcher sums, counters
// and the result item for the byte taken in this cycle.
// ----------------------------------------------------------------------------
module sfp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  sfp_pkg::cfg_t    cfg,
    output logic             res_valid,
    output sfp_pkg::result_t res
);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] len_full;
    logic [15:0] pos_inc;
    logic        nav;

    assign add_a    = sum_a_reg + rx_byte;
    assign add_b    = sum_b_reg + add_a;
    assign len_full = {rx_byte, len_reg[7:0]};
    assign pos_inc  = pos_reg + 16'd1;
    assign nav      = (class_reg == sfp_pkg::NAV_CLASS) && (id_reg == sfp_pkg::NAV_PVT_ID)
                      && (len_reg >= cfg.nav_min_length);

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        res_valid  = 1'b0;

        res                 = '0;
        res.frame_class     = class_reg;
        res.msg_id          = id_reg;
        res.frame_length    = len_reg;
        res.good_frames     = good_reg;
        res.checksum_errors = bad_reg;

        unique case (phase_reg)
            PH_SYNC2:
            begin
                if (rx_byte == sfp_pkg::SYNC_SECOND)
                begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                    phase_next = PH_CLASS;
                end
                else if (rx_byte == sfp_pkg::SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, rx_byte};
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (len_full > cfg.max_payload_length)
                begin
                    // Oversize frame: back to the sync search without a report.
                    phase_next = PH_SYNC1;
                    len_next   = '0;
                    pos_next   = '0;
                    sum_a_next = '0;
                    sum_b_next = '0;
                end
                else
                begin
                    len_next   = len_full;
                    pos_next   = '0;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next     = add_a;
                sum_b_next     = add_b;
                pos_next       = pos_inc;
                if (pos_inc >= len_reg)
                begin
                    phase_next = PH_CK_A;
                end
                res_valid      = 1'b1;
                res.kind       = sfp_pkg::KIND_PAYLOAD;
                res.byte_index = pos_reg;
                res.data_byte  = rx_byte;
            end
            PH_CK_A:
            begin
                if (rx_byte == sum_a_reg)
                begin
                    phase_next = PH_CK_B;
                end
                else
                begin
                    bad_next            = bad_reg + 32'd1;
                    res_valid           = 1'b1;
                    res.kind            = sfp_pkg::KIND_CK_ERR;
                    res.checksum_errors = bad_next;
                    phase_next          = PH_SYNC1;
                    len_next            = '0;
                    pos_next            = '0;
                    sum_a_next          = '0;
                    sum_b_next          = '0;
                end
            end
            PH_CK_B:
            begin
                res_valid = 1'b1;
                if (rx_byte == sum_b_reg)
                begin
                    good_next           = good_reg + 32'd1;
                    res.kind            = sfp_pkg::KIND_GOOD;
                    res.is_nav_solution = nav;
                    res.good_frames     = good_next;
                end
                else
                begin
                    bad_next            = bad_reg + 32'd1;
                    res.kind            = sfp_pkg::KIND_CK_ERR;
                    res.checksum_errors = bad_next;
                end
                phase_next = PH_SYNC1;
                len_next   = '0;
                pos_next   = '0;
                sum_a_next = '0;
                sum_b_next = '0;
            end
            default:
            begin
                // The sync search, and any code with no meaning.
                phase_next = (rx_byte == sfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            good_reg  <= '0;
            bad_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
        end
    end

`ifndef SYNTHESIS
    // Inside the payload the position never reaches the declared length.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (pos_reg < len_reg))
        else $error("payload position beyond declared length");

    // The good frame counter only moves on the second check byte.
    a_good_only_ckb: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg != PH_CK_B)) |=> $stable(good_reg))
        else $error("good frame counter moved outside check byte B");

    // A frame report always leaves the parser in the sync search.
    a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && (res.kind != sfp_pkg::KIND_PAYLOAD))
        |=> (phase_reg == PH_SYNC1) && (sum_a_reg == 8'd0) && (sum_b_reg == 8'd0))
        else $error("parser not back in sync search after frame report");
`endif

endmodule

// ===== rtl/sfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// sfp_out_reg
// Result register that drives the master-side stream.
// ----------------------------------------------------------------------------
module sfp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfp_pkg::result_t res,
    output logic             m_tvalid,
    input  logic             m_tready,
    output sfp_pkg::result_t res_out
);

    logic             valid_reg, valid_next;
    sfp_pkg::result_t res_reg;

    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

`ifndef SYNTHESIS
    // A new result is loaded only into a free or draining slot.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || m_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== bench/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker
// Watches the parser's configuration port and both stream sides. It keeps
// its own model of the frame search, queues the reports each input beat
// should cause and compares every output beat, field by field, with the
// oldest report still waiting.
// ----------------------------------------------------------------------------
module sfp_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending,
    output int           payload_seen,
    output int           good_seen,
    output int           nav_seen,
    output int           ck_err_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        TAKE_CLASS,
        TAKE_ID,
        TAKE_LEN_LO,
        TAKE_LEN_HI,
        TAKE_PAYLOAD,
        TAKE_CK_A,
        TAKE_CK_B
    } parse_phase_e;

    parse_phase_e phase_m = HUNT_SYNC1;
    logic [7:0]   class_m = '0;
    logic [7:0]   id_m = '0;
    logic [15:0]  len_m = '0;
    logic [15:0]  pos_m = '0;
    logic [7:0]   fl_a = '0;
    logic [7:0]   fl_b = '0;
    logic [31:0]  good_m = '0;
    logic [31:0]  bad_m = '0;
    logic [15:0]  max_len_m = sfp_pkg::MAX_PAYLOAD_RESET;
    logic [15:0]  nav_min_m = sfp_pkg::NAV_MIN_RESET;

    sfp_pkg::result_t expected_reports[$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        payload_seen = 0;
        good_seen    = 0;
        nav_seen     = 0;
        ck_err_seen  = 0;
    end

    function automatic void restart_hunt();
        phase_m = HUNT_SYNC1;
        pos_m   = '0;
        len_m   = '0;
        fl_a    = '0;
        fl_b    = '0;
    endfunction

    function automatic void fold_into_sum(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    function automatic void queue_report(input logic [1:0] kind, input logic [15:0] idx,
                                         input logic [7:0] data, input logic nav);
        sfp_pkg::result_t r;
        r.kind            = kind;
        r.frame_class     = class_m;
        r.msg_id          = id_m;
        r.byte_index      = idx;
        r.data_byte       = data;
        r.frame_length    = len_m;
        r.is_nav_solution = nav;
        r.good_frames     = good_m;
        r.checksum_errors = bad_m;
        expected_reports.push_back(r);
    endfunction

    // One received byte through the frame search.
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic nav;
        case (phase_m)
            HUNT_SYNC2:
            begin
                if (b == sfp_pkg::SYNC_SECOND)
                begin
                    fl_a    = '0;
                    fl_b    = '0;
                    phase_m = TAKE_CLASS;
                end
                else if (b != sfp_pkg::SYNC_FIRST)
                    phase_m = HUNT_SYNC1;
            end
            TAKE_CLASS:
            begin
                class_m = b;
                fold_into_sum(b);
                phase_m = TAKE_ID;
            end
            TAKE_ID:
            begin
                id_m = b;
                fold_into_sum(b);
                phase_m = TAKE_LEN_LO;
            end
            TAKE_LEN_LO:
            begin
                len_m = {8'h00, b};
                fold_into_sum(b);
                phase_m = TAKE_LEN_HI;
            end
            TAKE_LEN_HI:
            begin
                len_m[15:8] = b;
                fold_into_sum(b);
                if (len_m > max_len_m)
                    restart_hunt();
                else
                begin
                    pos_m   = '0;
                    phase_m = (len_m == 16'd0) ? TAKE_CK_A : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD:
            begin
                fold_into_sum(b);
                queue_report(sfp_pkg::KIND_PAYLOAD, pos_m, b, 1'b0);
                pos_m = pos_m + 16'd1;
                if (pos_m >= len_m)
                    phase_m = TAKE_CK_A;
            end
            TAKE_CK_A:
            begin
                if (b == fl_a)
                    phase_m = TAKE_CK_B;
                else
                begin
                    bad_m = bad_m + 32'd1;
                    queue_report(sfp_pkg::KIND_CK_ERR, '0, '0, 1'b0);
                    restart_hunt();
                end
            end
            TAKE_CK_B:
            begin
                if (b == fl_b)
                begin
                    nav = (class_m == sfp_pkg::NAV_CLASS) && (id_m == sfp_pkg::NAV_PVT_ID) &&
                          (len_m >= nav_min_m);
                    good_m = good_m + 32'd1;
                    queue_report(sfp_pkg::KIND_GOOD, '0, '0, nav);
                end
                else
                begin
                    bad_m = bad_m + 32'd1;
                    queue_report(sfp_pkg::KIND_CK_ERR, '0, '0, 1'b0);
                end
                restart_hunt();
            end
            default:
                phase_m = (b == sfp_pkg::SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
        endcase
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfp_pkg::result_t want;
        sfp_pkg::result_t seen;
        int               wrong;
        if (!rst_n)
        begin
            class_m   = '0;
            id_m      = '0;
            good_m    = '0;
            bad_m     = '0;
            max_len_m = sfp_pkg::MAX_PAYLOAD_RESET;
            nav_min_m = sfp_pkg::NAV_MIN_RESET;
            restart_hunt();
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            // Results leave before the new beat's report is queued, so a stray
            // output beat can never be matched against a report not yet due.
            if (m_tvalid && m_tready)
            begin
                seen.kind            = m_tuser;
                seen.frame_class     = m_tdata[7:0];
                seen.msg_id          = m_tdata[15:8];
                seen.byte_index      = m_tdata[31:16];
                seen.data_byte       = m_tdata[39:32];
                seen.frame_length    = m_tdata[55:40];
                seen.is_nav_solution = m_tdata[56];
                seen.good_frames     = m_tdata[88:57];
                seen.checksum_errors = m_tdata[120:89];
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected output beat, kind 0x%0h, expected none",
                             $time, seen.kind);
                    fail_count++;
                end
                else
                begin
                    want  = expected_reports.pop_front();
                    wrong = 0;
                    wrong += field_mismatch("kind", 32'(want.kind), 32'(seen.kind));
                    wrong += field_mismatch("frame_class", 32'(want.frame_class),
                                            32'(seen.frame_class));
                    wrong += field_mismatch("msg_id", 32'(want.msg_id), 32'(seen.msg_id));
                    wrong += field_mismatch("byte_index", 32'(want.byte_index),
                                            32'(seen.byte_index));
                    wrong += field_mismatch("data_byte", 32'(want.data_byte),
                                            32'(seen.data_byte));
                    wrong += field_mismatch("frame_length", 32'(want.frame_length),
                                            32'(seen.frame_length));
                    wrong += field_mismatch("is_nav_solution", 32'(want.is_nav_solution),
                                            32'(seen.is_nav_solution));
                    wrong += field_mismatch("good_frames", want.good_frames,
                                            seen.good_frames);
                    wrong += field_mismatch("checksum_errors", want.checksum_errors,
                                            seen.checksum_errors);
                    if (wrong != 0)
                        fail_count++;
                    case (want.kind)
                        sfp_pkg::KIND_PAYLOAD: payload_seen++;
                        sfp_pkg::KIND_GOOD:
                        begin
                            good_seen++;
                            if (want.is_nav_solution)
                                nav_seen++;
                        end
                        default: ck_err_seen++;
                    endcase
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == sfp_pkg::CFG_MAX_PAYLOAD)
                    max_len_m = cfg_data;
                else
                    nav_min_m = cfg_data;
            end

            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);

            pending <= expected_reports.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sync frame parser: a short directed set of frames and
// sync corner cases, then random frames with noise, checksum faults and
// oversize headers under several register settings, with random gaps on the
// sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS  = 28;
    localparam int NUM_PHASES   = 6;

    localparam logic [15:0] MAX_PLAN [NUM_PHASES] =
        '{16'd0, 16'hFFFF, 16'd12, 16'hFFFF, 16'd6, 16'd512};
    localparam logic [15:0] NAV_PLAN [NUM_PHASES] =
        '{16'd0, 16'hFFFF, 16'd0, 16'd6, 16'hFFFF, 16'd92};

    typedef enum int {
        FRAME_OK,
        FRAME_BAD_A,
        FRAME_BAD_B,
        FRAME_HEADER_ONLY
    } frame_flaw_e;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    int fail_count;
    int pending;
    int payload_seen;
    int good_seen;
    int nav_seen;
    int ck_err_seen;

    int          cycle_count = 0;
    int          beats_sent = 0;
    int          frame_beats = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    logic [15:0] cur_max = sfp_pkg::MAX_PAYLOAD_RESET;

    sync_frame_fletcher_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sfp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .payload_seen (payload_seen),
        .good_seen    (good_seen),
        .nav_seen     (nav_seen),
        .ck_err_seen  (ck_err_seen)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d reports outstanding",
                 cycle_count, pending);
        $display("FAIL sync_frame_fletcher_parser_top");
        $finish;
    end

    // Receiving side: a random stall before each beat, with calm stretches.
    initial
    begin
        int wait_cycles;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            wait_cycles = rx_calm ? 0 : $urandom_range(0, 4);
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_summed(input logic [7:0] b, inout logic [7:0] ck_a,
                               inout logic [7:0] ck_b);
        send_byte(b);
        frame_beats++;
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input frame_flaw_e flaw);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] hdr [4];
        ck_a   = '0;
        ck_b   = '0;
        hdr[0] = cls;
        hdr[1] = id;
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        send_byte(sfp_pkg::SYNC_FIRST);
        send_byte(sfp_pkg::SYNC_SECOND);
        frame_beats += 2;
        foreach (hdr[i])
            send_summed(hdr[i], ck_a, ck_b);
        if (flaw == FRAME_HEADER_ONLY)
            return;
        for (int i = 0; i < int'(len); i++)
            send_summed(8'($urandom), ck_a, ck_b);
        if (flaw == FRAME_BAD_A)
        begin
            send_byte(ck_a ^ 8'($urandom_range(1, 255)));
            frame_beats++;
            return;
        end
        send_byte(ck_a);
        if (flaw == FRAME_BAD_B)
            send_byte(ck_b ^ 8'($urandom_range(1, 255)));
        else
            send_byte(ck_b);
        frame_beats += 2;
    endtask

    // Line noise between frames; a stray 0x62 is kept out so that noise never
    // opens a frame by accident.
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            b = ($urandom_range(0, 3) == 0) ? sfp_pkg::SYNC_FIRST : 8'($urandom);
            if (b == sfp_pkg::SYNC_SECOND)
                b = 8'h63;
            send_byte(b);
        end
    endtask

    // Holds the sender back until every report has arrived and the pipeline
    // has had time to settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sfp_pkg::CFG_MAX_PAYLOAD)
            cur_max = val;
    endtask

    task automatic send_random_frame();
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        int          pick;
        frame_flaw_e flaw;
        cls  = ($urandom_range(0, 2) == 0) ? sfp_pkg::NAV_CLASS : 8'($urandom);
        id   = ($urandom_range(0, 1) == 0) ? sfp_pkg::NAV_PVT_ID : 8'($urandom);
        len  = 16'($urandom_range(0, 10));
        pick = $urandom_range(0, 9);
        flaw = FRAME_OK;
        if (pick == 1)
            flaw = FRAME_BAD_A;
        else if (pick == 2)
            flaw = FRAME_BAD_B;
        else if (pick == 0 && cur_max != 16'hFFFF)
        begin
            if ($urandom_range(0, 1) == 0)
                len = cur_max + 16'd1;
            else
                len = 16'(cur_max + 1 + $urandom_range(0, 16'hFFFF - cur_max - 1));
        end
        if (len > cur_max)
            flaw = FRAME_HEADER_ONLY;
        send_frame(cls, id, len, flaw);
    endtask

    initial
    begin
        bit long_sent;
        int held_beats;
        long_sent = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: a repeated sync byte ahead of a short
        // navigation frame, which stays unflagged below the default minimum.
        send_byte(sfp_pkg::SYNC_FIRST);
        send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd3, FRAME_OK);
        // A sync byte followed by anything else drops back to the search.
        send_byte(sfp_pkg::SYNC_FIRST);
        send_byte(8'h00);
        send_frame(8'hFF, 8'hFF, 16'd0, FRAME_OK);
        send_frame(8'h00, 8'h00, 16'd1, FRAME_BAD_A);
        send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd2, FRAME_BAD_B);
        send_frame(8'h0A, 8'h0B, 16'hFFFF, FRAME_HEADER_ONLY);
        send_frame(8'h0C, 8'h0D, 16'd513, FRAME_HEADER_ONLY);
        drain();

        // Length limits right at the boundaries.
        write_reg(sfp_pkg::CFG_MAX_PAYLOAD, 16'd4);
        write_reg(sfp_pkg::CFG_NAV_MIN, 16'd3);
        send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd3, FRAME_OK);
        send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd4, FRAME_OK);
        send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd5, FRAME_HEADER_ONLY);
        send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd2, FRAME_OK);
        drain();

        frame_beats = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(sfp_pkg::CFG_MAX_PAYLOAD, MAX_PLAN[p]);
            write_reg(sfp_pkg::CFG_NAV_MIN, NAV_PLAN[p]);
            while (frame_beats < PHASE_BEATS * (p + 1))
            begin
                if ($urandom_range(0, 5) == 0)
                    tx_calm = !tx_calm;
                if ($urandom_range(0, 1) == 0)
                    send_noise($urandom_range(1, 3));
                send_random_frame();
            end
            // One longer payload to reach the high byte of the length; it is
            // kept out of the per-setting budget so later settings still run.
            if (MAX_PLAN[p] == 16'hFFFF && !long_sent)
            begin
                held_beats = frame_beats;
                send_frame(sfp_pkg::NAV_CLASS, sfp_pkg::NAV_PVT_ID, 16'd256, FRAME_OK);
                frame_beats = held_beats;
                long_sent = 1'b1;
            end
            drain();
        end

        $display("Sent %0d input beats across %0d register settings.",
                 beats_sent, NUM_PHASES + 2);
        $display("Checked %0d payload beats, %0d good frames (%0d navigation), %0d errors.",
                 payload_seen, good_seen, nav_seen, ck_err_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS sync_frame_fletcher_parser_top");
        else
            $display("FAIL sync_frame_fletcher_parser_top");
        $finish;
    end

endmodule
